// ----- src/pmaf_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types
// for the pad menu and autofire block. No dependencies.
package pmaf_pkg;

   localparam int unsigned PadWidth   = 16;
   localparam int unsigned CsrIdxW    = 3;
   localparam int unsigned CsrDataW   = 8;
   localparam int unsigned RemWidth   = 9;
   localparam int unsigned RemCountW  = 4;

   localparam logic [RemCountW-1:0] RemSteps = RemCountW'(RemWidth);

   localparam int unsigned BitUp     = 4;
   localparam int unsigned BitRight  = 5;
   localparam int unsigned BitDown   = 6;
   localparam int unsigned BitLeft   = 7;
   localparam int unsigned BitMenu   = 10;
   localparam int unsigned BitTurboA = 12;
   localparam int unsigned BitA      = 13;
   localparam int unsigned BitB      = 14;
   localparam int unsigned BitTurboB = 15;

   localparam logic [PadWidth-1:0] AnyMask = 16'hFCF9;

   localparam logic [CsrIdxW-1:0] CSR_TURBO_LEVELS = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_COUNTER_WRAP = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MENU_HOLD    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_REPEAT_HOLD  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_VOLUME_MAX   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_BRIGHT_MAX   = 3'd5;

   localparam logic [3:0] RstTurboLevels = 4'd6;
   localparam logic [7:0] RstCounterWrap = 8'd210;
   localparam logic [7:0] RstMenuHold    = 8'd20;
   localparam logic [7:0] RstRepeatHold  = 8'd15;
   localparam logic [3:0] RstVolumeMax   = 4'd4;
   localparam logic [3:0] RstBrightMax   = 4'd4;
   localparam logic [3:0] RstVolLevel    = 4'd3;
   localparam logic [3:0] RstBrightLevel = 4'd4;
   localparam logic [3:0] RstRate        = 4'd3;

   typedef struct packed {
      logic accept;
      logic start;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic rem_done;
   } status_type;

endpackage

// ----- src/pmaf_rem.sv -----
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on pmaf_pkg for widths.
module pmaf_rem (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pmaf_pkg::RemWidth-1:0]    dividend,
   input  logic [pmaf_pkg::RemWidth-1:0]    divisor,
   output logic [pmaf_pkg::RemWidth-1:0]    remainder,
   output logic                             done
);
   import pmaf_pkg::*;

   logic [RemWidth-1:0]  rem_ff, rem_in;
   logic [RemWidth-1:0]  shift_ff, shift_in;
   logic [RemWidth-1:0]  div_ff, div_in;
   logic [RemCountW-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [RemWidth:0]    trial;

   always_comb begin
      trial    = {rem_ff, shift_ff[RemWidth-1]};
      rem_in   = rem_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         shift_in = dividend;
         div_in   = divisor;
         cnt_in   = RemSteps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = RemWidth'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[RemWidth-1:0];
         end
         shift_in = {shift_ff[RemWidth-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == RemCountW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ----- src/pmaf_ctrl.sv -----
// Sequencer for one poll: accept, start remainders, commit, present result.
// Depends on pmaf_pkg for command and status types.
module pmaf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pmaf_pkg::status_type   status,
   output pmaf_pkg::cmd_type      cmd
);
   import pmaf_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_RUN   = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_START;
         end
         S_START: state_in = S_RUN;
         S_RUN: begin
            if (status.rem_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT);
   assign cmd.accept = (state_ff == S_IDLE) && req_valid;
   assign cmd.start  = (state_ff == S_START);
   assign cmd.commit = (state_ff == S_RUN) && status.rem_done;

endmodule

// ----- src/pmaf_dp.sv -----
// Datapath: settings registers, menu/autofire state, four remainder lanes
// and the result register. Depends on pmaf_pkg and pmaf_rem.
module pmaf_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  pmaf_pkg::cmd_type                 cmd,
   output pmaf_pkg::status_type              status,
   input  logic                              csr_wr_en,
   input  logic [pmaf_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [pmaf_pkg::CsrDataW-1:0]     csr_wdata,
   input  logic [pmaf_pkg::PadWidth-1:0]     req_pad_in,
   output logic [pmaf_pkg::PadWidth-1:0]     rsp_pad_out,
   output logic                              rsp_menu_visible,
   output logic [3:0]                        rsp_volume_now,
   output logic [3:0]                        rsp_brightness_now,
   output logic                              rsp_stretch_x,
   output logic                              rsp_stretch_y,
   output logic [3:0]                        rsp_autofire_a_rate,
   output logic [3:0]                        rsp_autofire_b_rate
);
   import pmaf_pkg::*;

   logic [3:0] turbo_levels_ff;
   logic [7:0] counter_wrap_ff, menu_hold_ff, repeat_hold_ff;
   logic [3:0] volume_max_ff, bright_max_ff;

   logic [7:0]          hold_ff, hold_in;
   logic                menu_ff, menu_in;
   logic [3:0]          vol_ff, vol_in, bright_ff, bright_in;
   logic                xs_ff, xs_in, ys_ff, ys_in;
   logic [3:0]          rate_a_ff, rate_a_in, rate_b_ff, rate_b_in;
   logic [7:0]          phase_a_ff, phase_a_in, phase_b_ff, phase_b_in;
   logic [PadWidth-1:0] word_ff, word_in;

   logic [PadWidth-1:0] pad_out_ff, pad_out_in;
   logic                menu_out_ff;
   logic [3:0]          vol_out_ff, bright_out_ff, rate_a_out_ff, rate_b_out_ff;
   logic                xs_out_ff, ys_out_ff;

   logic [7:0]          hold_dec;
   logic                menu_toggle;
   logic [3:0]          levels;
   logic [RemWidth-1:0] wrap;
   logic [RemWidth-1:0] fa_dividend, fa_divisor, fb_dividend, fb_divisor;
   logic [RemWidth-1:0] pa_dividend, pb_dividend;
   logic [RemWidth-1:0] fa_rem, fb_rem, pa_rem, pb_rem;
   logic                fa_done, fb_done, pa_done, pb_done;
   logic [3:0]          vol_step;
   logic [3:0]          bright_step;

   function automatic logic pressed(input logic [PadWidth-1:0] w, input int unsigned b);
      pressed = !w[b];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         turbo_levels_ff <= RstTurboLevels;
         counter_wrap_ff <= RstCounterWrap;
         menu_hold_ff    <= RstMenuHold;
         repeat_hold_ff  <= RstRepeatHold;
         volume_max_ff   <= RstVolumeMax;
         bright_max_ff   <= RstBrightMax;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TURBO_LEVELS: turbo_levels_ff <= csr_wdata[3:0];
            CSR_COUNTER_WRAP: counter_wrap_ff <= csr_wdata;
            CSR_MENU_HOLD:    menu_hold_ff    <= csr_wdata;
            CSR_REPEAT_HOLD:  repeat_hold_ff  <= csr_wdata;
            CSR_VOLUME_MAX:   volume_max_ff   <= csr_wdata[3:0];
            CSR_BRIGHT_MAX:   bright_max_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      levels      = (turbo_levels_ff != 4'd0) ? turbo_levels_ff : 4'd1;
      wrap        = (counter_wrap_ff != 8'd0) ? {1'b0, counter_wrap_ff} : 9'd256;
      fa_dividend = menu_ff ? RemWidth'(rate_a_ff) + 1'b1 : {1'b0, phase_a_ff};
      fb_dividend = menu_ff ? RemWidth'(rate_b_ff) + 1'b1 : {1'b0, phase_b_ff};
      fa_divisor  = menu_ff ? RemWidth'(levels) : {4'd0, rate_a_ff, 1'b0};
      fb_divisor  = menu_ff ? RemWidth'(levels) : {4'd0, rate_b_ff, 1'b0};
      pa_dividend = {1'b0, phase_a_ff} + 1'b1;
      pb_dividend = {1'b0, phase_b_ff} + 1'b1;
   end

   pmaf_rem u_rem_fa (
      .clock(clock), .reset(reset), .start(cmd.start),
      .dividend(fa_dividend), .divisor(fa_divisor),
      .remainder(fa_rem), .done(fa_done)
   );
   pmaf_rem u_rem_fb (
      .clock(clock), .reset(reset), .start(cmd.start),
      .dividend(fb_dividend), .divisor(fb_divisor),
      .remainder(fb_rem), .done(fb_done)
   );
   pmaf_rem u_rem_pa (
      .clock(clock), .reset(reset), .start(cmd.start),
      .dividend(pa_dividend), .divisor(wrap),
      .remainder(pa_rem), .done(pa_done)
   );
   pmaf_rem u_rem_pb (
      .clock(clock), .reset(reset), .start(cmd.start),
      .dividend(pb_dividend), .divisor(wrap),
      .remainder(pb_rem), .done(pb_done)
   );

   assign status.rem_done = fa_done & fb_done & pa_done & pb_done;

   always_comb begin
      hold_in     = hold_ff;
      menu_in     = menu_ff;
      vol_in      = vol_ff;
      bright_in   = bright_ff;
      xs_in       = xs_ff;
      ys_in       = ys_ff;
      rate_a_in   = rate_a_ff;
      rate_b_in   = rate_b_ff;
      phase_a_in  = phase_a_ff;
      phase_b_in  = phase_b_ff;
      word_in     = word_ff;
      pad_out_in  = word_ff;
      hold_dec    = (hold_ff != 8'd0) ? hold_ff - 1'b1 : 8'd0;
      menu_toggle = pressed(req_pad_in, BitMenu) && (hold_dec == 8'd0);
      vol_step    = vol_ff;
      bright_step = bright_ff;

      if (cmd.accept) begin
         word_in = req_pad_in;
         hold_in = menu_toggle ? menu_hold_ff : hold_dec;
         menu_in = menu_ff ^ menu_toggle;
      end

      if (cmd.commit) begin
         if (menu_ff) begin
            if (hold_ff == 8'd0) begin
               if (pressed(word_ff, BitUp) && (vol_step < volume_max_ff))
                  vol_step = vol_step + 1'b1;
               if (pressed(word_ff, BitDown) && (vol_step != 4'd0))
                  vol_step = vol_step - 1'b1;
               if (pressed(word_ff, BitRight) && (bright_step < bright_max_ff))
                  bright_step = bright_step + 1'b1;
               if (pressed(word_ff, BitLeft) && (bright_step != 4'd0))
                  bright_step = bright_step - 1'b1;
               vol_in    = vol_step;
               bright_in = bright_step;
               if (pressed(word_ff, BitA)) ys_in = !ys_ff;
               if (pressed(word_ff, BitB)) xs_in = !xs_ff;
               if (pressed(word_ff, BitTurboA)) rate_a_in = fa_rem[3:0];
               if (pressed(word_ff, BitTurboB)) rate_b_in = fb_rem[3:0];
               if ((~word_ff & AnyMask) != '0) hold_in = repeat_hold_ff;
            end
         end else begin
            if ((rate_a_ff != 4'd0) && pressed(word_ff, BitTurboA)) begin
               pad_out_in[BitA] = (fa_rem != '0);
               phase_a_in       = pa_rem[7:0];
            end else begin
               phase_a_in = 8'd0;
            end
            if ((rate_b_ff != 4'd0) && pressed(word_ff, BitTurboB)) begin
               pad_out_in[BitB] = (fb_rem != '0);
               phase_b_in       = pb_rem[7:0];
            end else begin
               phase_b_in = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff    <= 8'd0;
         menu_ff    <= 1'b0;
         vol_ff     <= RstVolLevel;
         bright_ff  <= RstBrightLevel;
         xs_ff      <= 1'b0;
         ys_ff      <= 1'b0;
         rate_a_ff  <= RstRate;
         rate_b_ff  <= RstRate;
         phase_a_ff <= 8'd0;
         phase_b_ff <= 8'd0;
      end else begin
         hold_ff    <= hold_in;
         menu_ff    <= menu_in;
         vol_ff     <= vol_in;
         bright_ff  <= bright_in;
         xs_ff      <= xs_in;
         ys_ff      <= ys_in;
         rate_a_ff  <= rate_a_in;
         rate_b_ff  <= rate_b_in;
         phase_a_ff <= phase_a_in;
         phase_b_ff <= phase_b_in;
      end
      word_ff <= word_in;
      if (cmd.commit) begin
         pad_out_ff    <= pad_out_in;
         menu_out_ff   <= menu_ff;
         vol_out_ff    <= vol_in;
         bright_out_ff <= bright_in;
         xs_out_ff     <= xs_in;
         ys_out_ff     <= ys_in;
         rate_a_out_ff <= rate_a_in;
         rate_b_out_ff <= rate_b_in;
      end
   end

   assign rsp_pad_out         = pad_out_ff;
   assign rsp_menu_visible    = menu_out_ff;
   assign rsp_volume_now      = vol_out_ff;
   assign rsp_brightness_now  = bright_out_ff;
   assign rsp_stretch_x       = xs_out_ff;
   assign rsp_stretch_y       = ys_out_ff;
   assign rsp_autofire_a_rate = rate_a_out_ff;
   assign rsp_autofire_b_rate = rate_b_out_ff;

endmodule

// ----- src/pad_menu_and_autofire.sv -----
// Top level of the pad menu and autofire block: controller plus datapath.
// Depends on pmaf_pkg, pmaf_ctrl, pmaf_dp (and pmaf_rem below it).
//
//   channel | ports                         | handshake
//   req     | req_pad_in                    | req_valid / req_stall
//   rsp     | rsp_pad_out ... rsp_*_rate    | rsp_valid / rsp_stall
//   csr     | csr_index, csr_wdata          | csr_wr_en, no wait
//
// One poll at a time: accept, the start state, nine remainder steps (the
// 9-bit restoring remainder lanes set this), commit as the lanes finish,
// then the result is offered until taken with rsp_stall low, after which
// the next poll may be accepted. req_stall is high once a poll is accepted
// until the result beat is taken. Synchronous reset restores settings, menu,
// autofire and control state to defaults, not the result; no clearing pass.
module pad_menu_and_autofire (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pmaf_pkg::PadWidth-1:0]  req_pad_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pmaf_pkg::PadWidth-1:0]  rsp_pad_out,
   output logic                           rsp_menu_visible,
   output logic [3:0]                     rsp_volume_now,
   output logic [3:0]                     rsp_brightness_now,
   output logic                           rsp_stretch_x,
   output logic                           rsp_stretch_y,
   output logic [3:0]                     rsp_autofire_a_rate,
   output logic [3:0]                     rsp_autofire_b_rate,
   input  logic                           csr_wr_en,
   input  logic [pmaf_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [pmaf_pkg::CsrDataW-1:0]  csr_wdata
);
   import pmaf_pkg::*;

   cmd_type    cmd;
   status_type status;

   pmaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pmaf_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_pad_in          (req_pad_in),
      .rsp_pad_out         (rsp_pad_out),
      .rsp_menu_visible    (rsp_menu_visible),
      .rsp_volume_now      (rsp_volume_now),
      .rsp_brightness_now  (rsp_brightness_now),
      .rsp_stretch_x       (rsp_stretch_x),
      .rsp_stretch_y       (rsp_stretch_y),
      .rsp_autofire_a_rate (rsp_autofire_a_rate),
      .rsp_autofire_b_rate (rsp_autofire_b_rate)
   );

endmodule
